// ===== design/cld_pkg.sv =====
// Shared types and constants for the character literal decoder.
package cld_pkg;

    // Default depth of the queue between the classifier and the decoder.
    localparam int unsigned FIFO_DEPTH_DEF = 4;

    // Byte values the decoder recognizes.
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_CARET   = 8'h5e;
    localparam logic [7:0] CH_DASH    = 8'h2d;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_PAREN   = 8'h28;
    localparam logic [7:0] ASCII_MAX  = 8'h7f;
    localparam logic [7:0] LEAD2_MIN  = 8'hc2;
    localparam logic [7:0] LEAD2_MAX  = 8'hdf;
    localparam logic [7:0] LEAD3_MIN  = 8'he0;
    localparam logic [7:0] LEAD3_MAX  = 8'hef;
    localparam logic [15:0] CODE_TAB     = 16'd9;
    localparam logic [15:0] CODE_NEWLINE = 16'd10;
    localparam logic [7:0]  COUNT_MAX    = 8'hff;

    // One classified input byte as it travels through the queue.
    typedef struct packed {
        logic       eod;
        logic       is_hex;
        logic [3:0] nibble;
        logic [7:0] data;
    } byte_item_t;

    // One decoded literal.
    typedef struct packed {
        logic        ok;
        logic [15:0] code;
        logic [7:0]  count;
    } result_t;

endpackage

// ===== design/cld_front.sv =====
// Input stage: accepts byte transactions and classifies hex digits.
module cld_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_data,
    input  logic                 in_eod,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cld_pkg::byte_item_t  out_item
);

    logic                valid_reg;
    logic                valid_next;
    cld_pkg::byte_item_t item_reg;
    cld_pkg::byte_item_t item_next;
    logic                is_digit;
    logic                is_upper;
    logic                is_lower;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        is_digit = (in_data >= 8'h30) && (in_data <= 8'h39);
        is_upper = (in_data >= 8'h41) && (in_data <= 8'h46);
        is_lower = (in_data >= 8'h61) && (in_data <= 8'h66);
        item_next.eod    = in_eod;
        item_next.data   = in_data;
        item_next.is_hex = is_digit || is_upper || is_lower;
        // Letters map to 10..15 by their low three bits plus nine.
        if (is_digit) begin
            item_next.nibble = in_data[3:0];
        end else begin
            item_next.nibble = 4'(in_data[2:0] + 3'd1) + 4'd8;
        end
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/cld_fifo.sv =====
// Short queue of classified bytes between the input stage and the decoder.
module cld_fifo #(
    parameter int unsigned DEPTH = cld_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  cld_pkg::byte_item_t  push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output cld_pkg::byte_item_t  pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cld_pkg::byte_item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/cld_back.sv =====
// Decoder state machine and result register.
module cld_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cld_pkg::byte_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cld_pkg::result_t     out_result
);

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_CARET = 3'd1,
        PH_PAREN = 3'd2,
        PH_CONT  = 3'd3,
        PH_QUOTE = 3'd4
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [15:0]      code_reg;
    logic [15:0]      code_next;
    logic             two_left_reg;
    logic             two_left_next;
    logic [7:0]       count_reg;
    logic [7:0]       count_next;
    logic             valid_reg;
    logic             valid_next;
    cld_pkg::result_t result_reg;
    cld_pkg::result_t result_next;
    logic             take;
    logic             emit;
    logic             emit_ok;
    logic [7:0]       count_inc;
    logic [7:0]       b;

    // Bytes that finish no literal keep flowing while a result waits.
    assign in_ready   = !valid_reg || out_ready || !emit;
    assign take       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign b          = in_item.data;

    always_comb begin
        count_inc     = (count_reg == cld_pkg::COUNT_MAX) ? count_reg : count_reg + 8'd1;
        phase_next    = phase_reg;
        code_next     = code_reg;
        two_left_next = two_left_reg;
        count_next    = count_inc;
        emit          = 1'b0;
        emit_ok       = 1'b0;
        if (in_item.eod) begin
            emit = 1'b1;
        end else begin
            case (phase_reg)
                PH_CARET: begin
                    phase_next = PH_QUOTE;
                    if (in_item.is_hex) begin
                        code_next = {12'd0, in_item.nibble};
                    end else if (b == cld_pkg::CH_DASH) begin
                        code_next = cld_pkg::CODE_TAB;
                    end else if (b == cld_pkg::CH_SLASH) begin
                        code_next = cld_pkg::CODE_NEWLINE;
                    end else if (b == cld_pkg::CH_PAREN) begin
                        code_next  = '0;
                        phase_next = PH_PAREN;
                    end else begin
                        code_next = {8'd0, b};
                    end
                end
                PH_PAREN: begin
                    if (in_item.is_hex) begin
                        code_next = {code_reg[11:0], in_item.nibble};
                    end else begin
                        phase_next = PH_QUOTE;
                    end
                end
                PH_CONT: begin
                    if (two_left_reg) begin
                        code_next     = code_reg | {4'd0, b[5:0], 6'd0};
                        two_left_next = 1'b0;
                    end else begin
                        code_next  = code_reg | {10'd0, b[5:0]};
                        phase_next = PH_QUOTE;
                    end
                end
                PH_QUOTE: begin
                    emit    = 1'b1;
                    emit_ok = b == cld_pkg::CH_QUOTE;
                end
                default: begin
                    if (b <= cld_pkg::ASCII_MAX) begin
                        if (b == cld_pkg::CH_CARET) begin
                            phase_next = PH_CARET;
                        end else begin
                            code_next  = {8'd0, b};
                            phase_next = PH_QUOTE;
                        end
                    end else if (b inside {[cld_pkg::LEAD2_MIN:cld_pkg::LEAD2_MAX]}) begin
                        code_next     = {5'd0, b[4:0], 6'd0};
                        two_left_next = 1'b0;
                        phase_next    = PH_CONT;
                    end else if (b inside {[cld_pkg::LEAD3_MIN:cld_pkg::LEAD3_MAX]}) begin
                        code_next     = {b[3:0], 12'd0};
                        two_left_next = 1'b1;
                        phase_next    = PH_CONT;
                    end else begin
                        emit = 1'b1;
                    end
                end
            endcase
        end

        result_next.ok    = emit_ok;
        result_next.code  = emit_ok ? code_reg : 16'd0;
        result_next.count = emit_ok ? count_inc : 8'd0;

        if (emit) begin
            phase_next    = PH_FIRST;
            code_next     = '0;
            two_left_next = 1'b0;
            count_next    = '0;
        end

        if (in_valid && emit && (!valid_reg || out_ready)) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            code_reg     <= '0;
            two_left_reg <= 1'b0;
            count_reg    <= '0;
            valid_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                phase_reg    <= phase_next;
                code_reg     <= code_next;
                two_left_reg <= two_left_next;
                count_reg    <= count_next;
            end
        end
        if (take && emit) begin
            result_reg <= result_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !result_reg.ok |-> result_reg.code == 16'd0 && result_reg.count == 8'd0)
        else $error("invalid result carries nonzero payload");

    a_ok_min_count: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && result_reg.ok |-> result_reg.count >= 8'd2)
        else $error("valid literal shorter than two bytes");

    a_idle_is_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FIRST |-> code_reg == 16'd0 && count_reg == 8'd0)
        else $error("decoder idle with leftover state");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(result_reg))
        else $error("pending result lost or changed");
`endif

endmodule

// ===== design/char_literal_utf8_decoder_core.sv =====
// Top level of the character literal decoder: classifier, queue and decoder.
//
// This block decodes one quoted character literal at a time from a byte
// stream, starting with the byte after the opening quote. Each input
// transaction carries one byte in s_tdata, or, with s_tlast high, marks the
// end of the buffer (the byte is then ignored and an invalid result is
// produced). A literal is an ASCII byte, a caret escape (hex digit, '-' for
// tab, '/' for newline, '(' followed by hex digits ended by any non-hex byte,
// or any other byte taken literally), or a two- or three-byte UTF-8 sequence
// whose continuation bytes are not checked; a closing quote must follow. One
// result transaction comes out per literal: m_tuser is high for a valid
// literal, and m_tdata then holds the 16-bit code and the byte count
// including the closing quote, saturating at 255; an invalid literal (bad
// lead byte, missing quote or end of data) gives m_tuser low and all-zero
// m_tdata. After any result the next byte starts a new literal. The block
// takes one byte transaction per clock cycle while results are taken as they
// are offered; a result is offered once the transaction that completes it
// has moved from the input register through the queue and loaded the result
// register. The queue of FIFO_DEPTH entries between the input stage and the
// decoder absorbs short stalls on the result side, and the
// result register lets the decoder keep accepting bytes that produce no
// result while a finished result waits to be taken.
module char_literal_utf8_decoder_core #(
    parameter int unsigned FIFO_DEPTH = cld_pkg::FIFO_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] code_point, [23:16] bytes_used
    output logic        m_tuser    // decoded_ok
);

    logic                front_valid;
    logic                front_ready;
    cld_pkg::byte_item_t front_item;
    logic                queue_valid;
    logic                queue_ready;
    cld_pkg::byte_item_t queue_item;
    cld_pkg::result_t    result;

    // Input stage: registers each byte and classifies hex digits.
    cld_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_eod    (s_tlast),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // Queue that lets the input stage and the decoder stall independently.
    cld_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    // Decoder: walks the literal state machine and holds the result.
    cld_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result: code point in the low bits, byte count above it.
    assign m_tdata = {result.count, result.code};
    assign m_tuser = result.ok;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the character literal decoder core.
module tb_top;

    localparam logic [7:0]  CH_RPAREN     = 8'h29;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PRINT_LIMIT   = 40;

    // Decoder phases as the prediction tracks them.
    typedef enum logic [2:0] {
        LP_FIRST = 3'd0,
        LP_CARET = 3'd1,
        LP_PAREN = 3'd2,
        LP_CONT  = 3'd3,
        LP_QUOTE = 3'd4
    } lit_phase_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    char_literal_utf8_decoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predicted decoder state.
    lit_phase_t  lit_phase     = LP_FIRST;
    logic [15:0] lit_accum     = '0;
    logic [1:0]  lit_cont_left = '0;
    logic [7:0]  lit_count     = '0;

    cld_pkg::result_t expected_literals[$];

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned bytes_sent         = 0;
    int unsigned error_count        = 0;
    int unsigned literals_checked   = 0;
    int unsigned literals_ok        = 0;
    int unsigned longest_literal    = 0;
    int unsigned quiet_cycles       = 0;

    function automatic logic hex_char(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39)
            v = b - 8'h30;
        else if (b <= 8'h46)
            v = b - 8'h41 + 8'd10;
        else
            v = b - 8'h61 + 8'd10;
        return v[3:0];
    endfunction

    // Closes the current literal and queues the result it must produce.
    task automatic close_literal(input logic ok);
        cld_pkg::result_t r;
        r.ok    = ok;
        r.code  = ok ? lit_accum : 16'h0000;
        r.count = ok ? lit_count : 8'h00;
        expected_literals.push_back(r);
        lit_phase     = LP_FIRST;
        lit_accum     = '0;
        lit_cont_left = '0;
        lit_count     = '0;
    endtask

    // Advances the predicted decoder by one accepted byte transaction.
    task automatic decode_byte(input logic [7:0] b, input logic eod);
        if (eod) begin
            close_literal(1'b0);
            return;
        end
        if (lit_count != cld_pkg::COUNT_MAX)
            lit_count++;
        case (lit_phase)
            LP_CARET: begin
                lit_phase = LP_QUOTE;
                if (hex_char(b))
                    lit_accum = {12'h000, hex_value(b)};
                else if (b == cld_pkg::CH_DASH)
                    lit_accum = cld_pkg::CODE_TAB;
                else if (b == cld_pkg::CH_SLASH)
                    lit_accum = cld_pkg::CODE_NEWLINE;
                else if (b == cld_pkg::CH_PAREN) begin
                    lit_accum = '0;
                    lit_phase = LP_PAREN;
                end else
                    lit_accum = {8'h00, b};
            end
            LP_PAREN: begin
                // Any non-hex byte, a quote too, ends the number and is dropped.
                if (hex_char(b))
                    lit_accum = {lit_accum[11:0], hex_value(b)};
                else
                    lit_phase = LP_QUOTE;
            end
            LP_CONT: begin
                if (lit_cont_left == 2'd2) begin
                    lit_accum     = lit_accum | {4'h0, b[5:0], 6'h00};
                    lit_cont_left = 2'd1;
                end else begin
                    lit_accum     = lit_accum | {10'h000, b[5:0]};
                    lit_cont_left = 2'd0;
                    lit_phase     = LP_QUOTE;
                end
            end
            LP_QUOTE: begin
                close_literal(b == cld_pkg::CH_QUOTE);
            end
            default: begin
                if (b <= cld_pkg::ASCII_MAX) begin
                    if (b == cld_pkg::CH_CARET)
                        lit_phase = LP_CARET;
                    else begin
                        lit_accum = {8'h00, b};
                        lit_phase = LP_QUOTE;
                    end
                end else if (b >= cld_pkg::LEAD2_MIN && b <= cld_pkg::LEAD2_MAX) begin
                    lit_accum     = {5'h00, b[4:0], 6'h00};
                    lit_cont_left = 2'd1;
                    lit_phase     = LP_CONT;
                end else if (b >= cld_pkg::LEAD3_MIN && b <= cld_pkg::LEAD3_MAX) begin
                    lit_accum     = {b[3:0], 12'h000};
                    lit_cont_left = 2'd2;
                    lit_phase     = LP_CONT;
                end else
                    close_literal(1'b0);
            end
        endcase
    endtask

    // Sends one byte transaction and waits for it to be taken. Valid is left
    // high afterwards; the next call either drives new data or idles.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eod;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, eod);
        bytes_sent++;
    endtask

    task automatic send_eod();
        logic [7:0] junk;
        junk = 8'($urandom);
        send_byte(junk, 1'b1);
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int unsigned v;
        v = $urandom_range(21);
        if (v < 10)
            return 8'(8'h30 + v);
        else if (v < 16)
            return 8'(8'h41 + v - 10);
        return 8'(8'h61 + v - 16);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do b = 8'($urandom); while (hex_char(b));
        return b;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH literal %0d: %s got 0x%0h, expected 0x%0h",
                     literals_checked, what, got, want);
    endtask

    // Result checker: every accepted result transaction against the oldest prediction.
    always @(posedge aclk) begin
        cld_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_literals.size() == 0)
                report_mismatch("unexpected result, tdata", 32'(m_tdata), 0);
            else begin
                want = expected_literals.pop_front();
                if (m_tuser !== want.ok)
                    report_mismatch("decoded_ok", 32'(m_tuser), 32'(want.ok));
                if (m_tdata[15:0] !== want.code)
                    report_mismatch("code_point", 32'(m_tdata[15:0]), 32'(want.code));
                if (m_tdata[23:16] !== want.count)
                    report_mismatch("bytes_used", 32'(m_tdata[23:16]), 32'(want.count));
                if (want.ok) begin
                    literals_ok++;
                    if (want.count > longest_literal)
                        longest_literal = 32'(want.count);
                end
            end
            literals_checked++;
        end
    end

    // Result-side back-pressure.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Watchdog: too long without any transaction on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("[char_literal_utf8_decoder_core] ERROR");
            $finish;
        end
    end

    task automatic test_ascii_literals();
        send_byte(8'h00, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
        // Largest ASCII byte, then a byte where the closing quote belongs.
        send_byte(cld_pkg::ASCII_MAX, 1'b0);
        send_byte(8'h78, 1'b0);
    endtask

    task automatic test_caret_escapes();
        send_byte(cld_pkg::CH_CARET, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
        send_byte(cld_pkg::CH_CARET, 1'b0);
        send_byte(cld_pkg::CH_DASH, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
        send_byte(cld_pkg::CH_CARET, 1'b0);
        send_byte(cld_pkg::CH_SLASH, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
        // A quote ends the hex number and is dropped, so a second one closes.
        send_byte(cld_pkg::CH_CARET, 1'b0);
        send_byte(cld_pkg::CH_PAREN, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
        // A caret taken literally, then the buffer ends.
        send_byte(cld_pkg::CH_CARET, 1'b0);
        send_byte(cld_pkg::CH_CARET, 1'b0);
        send_eod();
    endtask

    task automatic test_utf8_sequences();
        send_byte(cld_pkg::LEAD2_MIN, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
        send_byte(cld_pkg::LEAD3_MAX, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
    endtask

    task automatic test_bad_leads_and_eod();
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_eod();
    endtask

    // More than 255 hex digits: count saturates, code keeps the low 16 bits.
    task automatic test_count_saturation();
        send_byte(cld_pkg::CH_CARET, 1'b0);
        send_byte(cld_pkg::CH_PAREN, 1'b0);
        repeat (300) send_byte(rand_hex_digit(), 1'b0);
        send_byte(CH_RPAREN, 1'b0);
        send_byte(cld_pkg::CH_QUOTE, 1'b0);
    endtask

    // One random literal: mostly well formed, some noise and broken endings.
    task automatic send_random_literal();
        int unsigned kind;
        int unsigned pick;
        logic [7:0]  b;
        kind = $urandom_range(99);
        if (kind < 8) begin
            b = 8'($urandom);
            send_byte(b, $urandom_range(9) == 0);
            return;
        end
        if (kind < 14) begin
            if ($urandom_range(1))
                b = 8'($urandom_range(8'h80, 8'hc1));
            else
                b = 8'($urandom_range(8'hf0, 8'hff));
            send_byte(b, 1'b0);
            return;
        end
        if (kind < 34) begin
            do b = 8'($urandom_range(cld_pkg::ASCII_MAX)); while (b == cld_pkg::CH_CARET);
            send_byte(b, 1'b0);
        end else if (kind < 64) begin
            send_byte(cld_pkg::CH_CARET, 1'b0);
            pick = $urandom_range(9);
            if (pick < 3)
                send_byte(rand_hex_digit(), 1'b0);
            else if (pick == 3)
                send_byte(cld_pkg::CH_DASH, 1'b0);
            else if (pick == 4)
                send_byte(cld_pkg::CH_SLASH, 1'b0);
            else if (pick < 8) begin
                send_byte(cld_pkg::CH_PAREN, 1'b0);
                repeat ($urandom_range(6)) send_byte(rand_hex_digit(), 1'b0);
                if ($urandom_range(9) < 7)
                    send_byte(CH_RPAREN, 1'b0);
                else
                    send_byte(rand_non_hex(), 1'b0);
            end else begin
                b = 8'($urandom);
                send_byte(b, 1'b0);
            end
        end else if (kind < 82) begin
            b = 8'($urandom_range(cld_pkg::LEAD2_MIN, cld_pkg::LEAD2_MAX));
            send_byte(b, 1'b0);
            b = 8'($urandom);
            send_byte(b, 1'b0);
        end else begin
            b = 8'($urandom_range(cld_pkg::LEAD3_MIN, cld_pkg::LEAD3_MAX));
            send_byte(b, 1'b0);
            repeat (2) begin
                b = 8'($urandom);
                send_byte(b, 1'b0);
            end
        end
        pick = $urandom_range(99);
        if (pick < 86)
            send_byte(cld_pkg::CH_QUOTE, 1'b0);
        else if (pick < 94) begin
            do b = 8'($urandom); while (b == cld_pkg::CH_QUOTE);
            send_byte(b, 1'b0);
        end else
            send_eod();
    endtask

    task automatic test_random_literals(input int unsigned byte_budget);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
            send_random_literal();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct    = 31;
        receiver_stall_pct = 84;
        test_ascii_literals();
        test_caret_escapes();
        test_utf8_sequences();
        test_bad_leads_and_eod();
        test_random_literals(440);

        sender_idle_pct    = 84;
        receiver_stall_pct = 31;
        test_random_literals(440);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_count_saturation();
        test_random_literals(440);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_literals.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d byte transactions; checked %0d literals, %0d decoded, %0d rejected.",
                 bytes_sent, literals_checked, literals_ok, literals_checked - literals_ok);
        $display("Longest decoded literal counted %0d bytes; %0d mismatches.",
                 longest_literal, error_count);
        if (error_count == 0)
            $display("[char_literal_utf8_decoder_core] OK");
        else
            $display("[char_literal_utf8_decoder_core] ERROR");
        $finish;
    end

endmodule
